// ===== hdl/mrce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrce_pkg - shared definitions of the row/column table editor
// Command codes, status codes, default sizes and the transfer payload types.
// ----------------------------------------------------------------------------
package mrce_pkg;

    // Default table geometry and cell width
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Command kinds
    localparam logic [3:0] K_WRITE     = 4'd0;
    localparam logic [3:0] K_READ      = 4'd1;
    localparam logic [3:0] K_SWAP_ROWS = 4'd2;
    localparam logic [3:0] K_SWAP_COLS = 4'd3;
    localparam logic [3:0] K_DEL_ROW   = 4'd4;
    localparam logic [3:0] K_DEL_COL   = 4'd5;
    localparam logic [3:0] K_INS_ROW   = 4'd6;
    localparam logic [3:0] K_INS_COL   = 4'd7;
    localparam logic [3:0] K_SET_SIZE  = 4'd8;

    // Result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_CAP   = 2'd2;

    // One command
    typedef struct packed {
        logic [3:0]         kind;
        logic [6:0]         first_index;
        logic [6:0]         second_index;
        logic signed [31:0] value;
    } t_in_item;

    // One result
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         rows_now;
        logic [6:0]         cols_now;
        logic [1:0]         status;
    } t_out_item;

endpackage
`default_nettype wire

// ===== hdl/mrce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrce_ram - cell store
// One write port and one read port with registered read data. No reset:
// contents are undefined until written.
// ----------------------------------------------------------------------------
module mrce_ram #(
    parameter int AW = 12,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Write one word, read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/mrce_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrce_step - shared index step unit
// Steps a walk index up or down by one and flags when it sits on its limit.
// ----------------------------------------------------------------------------
module mrce_step #(
    parameter int W = 11
) (
    input  wire logic [W-1:0] i_value,
    input  wire logic [W-1:0] i_limit,
    input  wire logic         i_down,
    output logic      [W-1:0] o_next,
    output logic              o_hit
);

    // Advance or retreat by one
    assign o_next = i_down ? (i_value - W'(1)) : (i_value + W'(1));

    // Last position of the walk
    assign o_hit  = (i_value == i_limit);

endmodule
`default_nettype wire

// ===== hdl/mrce_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrce_seq - command sequencer
// Checks each command against the current counts, then walks the affected
// cells one at a time through the cell store, stepping its walk indices with
// the shared step unit. Holds the row and column counts.
// ----------------------------------------------------------------------------
module mrce_seq #(
    parameter int MAX_ROWS   = mrce_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = mrce_pkg::MAX_COLS_DEF,
    parameter int DATA_WIDTH = mrce_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire mrce_pkg::t_in_item   i_cmd,
    output logic                      o_ready,
    input  wire logic                 i_out_free,
    output logic                      o_done,
    output mrce_pkg::t_out_item       o_result,
    output logic                      o_we,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] o_waddr,
    output logic [DATA_WIDTH-1:0]     o_wdata,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] o_raddr,
    input  wire logic [DATA_WIDTH-1:0] i_rdata
);

    import mrce_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int CNT_W = (RCW > CCW) ? RCW : CCW;
    localparam int IW    = (CNT_W > 7) ? CNT_W : 7;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_RD_WAIT = 4'd2;
    localparam logic [3:0] S_SW_RA   = 4'd3;
    localparam logic [3:0] S_SW_RB   = 4'd4;
    localparam logic [3:0] S_SW_WA   = 4'd5;
    localparam logic [3:0] S_SW_WB   = 4'd6;
    localparam logic [3:0] S_MV_RD   = 4'd7;
    localparam logic [3:0] S_MV_WR   = 4'd8;
    localparam logic [3:0] S_MV_NXT  = 4'd9;
    localparam logic [3:0] S_FILL    = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    // Control registers
    logic [3:0]     r_state, n_state;
    logic [RCW-1:0] r_rows,  n_rows;
    logic [CCW-1:0] r_cols,  n_cols;

    // Datapath registers
    logic [3:0]            r_kind, n_kind;
    logic [IW-1:0]         r_a, n_a;
    logic [IW-1:0]         r_b, n_b;
    logic [IW-1:0]         r_i, n_i;
    logic [IW-1:0]         r_j, n_j;
    logic [IW-1:0]         r_iend, n_iend;
    logic [IW-1:0]         r_jbeg, n_jbeg;
    logic [IW-1:0]         r_jend, n_jend;
    logic [IW-1:0]         r_fend, n_fend;
    logic                  r_idn, n_idn;
    logic                  r_jdn, n_jdn;
    logic                  r_fill, n_fill;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    logic signed [31:0]    r_rd, n_rd;
    logic [1:0]            r_st, n_st;

    logic [IW-1:0]        w_rows, w_cols, w_maxr, w_maxc;
    logic                 w_cell_ok;
    logic [63:0]          w_val64;
    logic signed [63:0]   w_rd64;
    logic                 w_outer;
    logic [IW-1:0]        w_sval, w_slim, w_snext;
    logic                 w_sdown, w_shit;
    logic [IW-1:0]        w_src_i, w_src_j;
    logic [AW-1:0]        w_cell_addr, w_a_addr, w_b_addr;
    logic [AW-1:0]        w_src_addr, w_dst_addr, w_fill_addr;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                                 input logic [IW-1:0] col);
        cell_addr = {row[RW-1:0], col[CW-1:0]};
    endfunction

    // Widen counts and limits for compares
    assign w_rows    = IW'(r_rows);
    assign w_cols    = IW'(r_cols);
    assign w_maxr    = IW'(MAX_ROWS);
    assign w_maxc    = IW'(MAX_COLS);
    assign w_cell_ok = (r_a < w_rows) && (r_b < w_cols);

    // Fit the command value to the cell width; sign-extend read data
    assign w_val64 = {{32{i_cmd.value[31]}}, i_cmd.value};
    assign w_rd64  = 64'($signed(i_rdata));

    // Route the walk index through the shared step unit
    assign w_outer = (r_state == S_MV_NXT);
    assign w_sval  = w_outer ? r_i    : r_j;
    assign w_slim  = w_outer ? r_iend : r_jend;
    assign w_sdown = w_outer ? r_idn  : r_jdn;

    mrce_step #(
        .W (IW)
    ) u_step (
        .i_value (w_sval),
        .i_limit (w_slim),
        .i_down  (w_sdown),
        .o_next  (w_snext),
        .o_hit   (w_shit)
    );

    // Source cell of a shift move
    always_comb begin
        w_src_i = r_i;
        w_src_j = r_j;
        case (r_kind)
            K_DEL_ROW: w_src_i = r_i + IW'(1);
            K_INS_ROW: w_src_i = r_i - IW'(1);
            K_DEL_COL: w_src_j = r_j + IW'(1);
            K_INS_COL: w_src_j = r_j - IW'(1);
            default:   w_src_i = r_i;
        endcase
    end

    // Cell addresses for each walk
    assign w_cell_addr = cell_addr(r_a, r_b);
    assign w_src_addr  = cell_addr(w_src_i, w_src_j);
    assign w_dst_addr  = cell_addr(r_i, r_j);
    assign w_a_addr    = (r_kind == K_SWAP_ROWS) ? cell_addr(r_a, r_j) : cell_addr(r_j, r_a);
    assign w_b_addr    = (r_kind == K_SWAP_ROWS) ? cell_addr(r_b, r_j) : cell_addr(r_j, r_b);
    assign w_fill_addr = (r_kind == K_INS_ROW)   ? cell_addr(r_a, r_j) : cell_addr(r_j, r_a);

    // Drive the cell store ports
    always_comb begin
        o_we    = 1'b0;
        o_waddr = w_cell_addr;
        o_wdata = r_val;
        o_raddr = w_cell_addr;
        case (r_state)
            S_DEC: begin
                o_we = (r_kind == K_WRITE) && w_cell_ok;
            end
            S_SW_RA: begin
                o_raddr = w_a_addr;
            end
            S_SW_RB: begin
                o_raddr = w_b_addr;
            end
            S_SW_WA: begin
                o_we    = 1'b1;
                o_waddr = w_a_addr;
                o_wdata = i_rdata;
            end
            S_SW_WB: begin
                o_we    = 1'b1;
                o_waddr = w_b_addr;
                o_wdata = r_tmp;
            end
            S_MV_RD: begin
                o_raddr = w_src_addr;
            end
            S_MV_WR: begin
                o_we    = 1'b1;
                o_waddr = w_dst_addr;
                o_wdata = i_rdata;
            end
            S_FILL: begin
                o_we    = 1'b1;
                o_waddr = w_fill_addr;
                o_wdata = '0;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    // Sequence each command
    always_comb begin
        n_state = r_state;
        n_rows  = r_rows;
        n_cols  = r_cols;
        n_kind  = r_kind;
        n_a     = r_a;
        n_b     = r_b;
        n_i     = r_i;
        n_j     = r_j;
        n_iend  = r_iend;
        n_jbeg  = r_jbeg;
        n_jend  = r_jend;
        n_fend  = r_fend;
        n_idn   = r_idn;
        n_jdn   = r_jdn;
        n_fill  = r_fill;
        n_val   = r_val;
        n_tmp   = r_tmp;
        n_rd    = r_rd;
        n_st    = r_st;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DEC;
                    n_kind  = i_cmd.kind;
                    n_a     = IW'(i_cmd.first_index);
                    n_b     = IW'(i_cmd.second_index);
                    n_val   = w_val64[DATA_WIDTH-1:0];
                    n_rd    = '0;
                    n_st    = ST_OK;
                end
            end
            S_DEC: begin
                n_state = S_DONE;
                n_jdn   = 1'b0;
                n_idn   = 1'b0;
                n_fill  = 1'b0;
                case (r_kind)
                    K_WRITE: begin
                        if (!w_cell_ok) begin
                            n_st = ST_RANGE;
                        end
                    end
                    K_READ: begin
                        if (!w_cell_ok) begin
                            n_st = ST_RANGE;
                        end else begin
                            n_state = S_RD_WAIT;
                        end
                    end
                    K_SWAP_ROWS: begin
                        if ((r_a >= w_rows) || (r_b >= w_rows)) begin
                            n_st = ST_RANGE;
                        end else if (w_cols != '0) begin
                            n_j     = '0;
                            n_jend  = w_cols - IW'(1);
                            n_state = S_SW_RA;
                        end
                    end
                    K_SWAP_COLS: begin
                        if ((r_a >= w_cols) || (r_b >= w_cols)) begin
                            n_st = ST_RANGE;
                        end else if (w_rows != '0) begin
                            n_j     = '0;
                            n_jend  = w_rows - IW'(1);
                            n_state = S_SW_RA;
                        end
                    end
                    K_DEL_ROW: begin
                        if (r_a >= w_rows) begin
                            n_st = ST_RANGE;
                        end else begin
                            n_rows = r_rows - RCW'(1);
                            if ((r_a != w_rows - IW'(1)) && (w_cols != '0)) begin
                                n_i     = r_a;
                                n_iend  = w_rows - IW'(2);
                                n_j     = '0;
                                n_jbeg  = '0;
                                n_jend  = w_cols - IW'(1);
                                n_state = S_MV_RD;
                            end
                        end
                    end
                    K_DEL_COL: begin
                        if (r_a >= w_cols) begin
                            n_st = ST_RANGE;
                        end else begin
                            n_cols = r_cols - CCW'(1);
                            if ((w_rows != '0) && (r_a != w_cols - IW'(1))) begin
                                n_i     = '0;
                                n_iend  = w_rows - IW'(1);
                                n_j     = r_a;
                                n_jbeg  = r_a;
                                n_jend  = w_cols - IW'(2);
                                n_state = S_MV_RD;
                            end
                        end
                    end
                    K_INS_ROW: begin
                        if (r_a > w_rows) begin
                            n_st = ST_RANGE;
                        end else if (w_rows >= w_maxr) begin
                            n_st = ST_CAP;
                        end else begin
                            n_rows = r_rows + RCW'(1);
                            n_fend = w_cols - IW'(1);
                            if (w_cols != '0) begin
                                if (r_a != w_rows) begin
                                    n_i     = w_rows;
                                    n_iend  = r_a + IW'(1);
                                    n_idn   = 1'b1;
                                    n_j     = '0;
                                    n_jbeg  = '0;
                                    n_jend  = w_cols - IW'(1);
                                    n_fill  = 1'b1;
                                    n_state = S_MV_RD;
                                end else begin
                                    n_j     = '0;
                                    n_jend  = w_cols - IW'(1);
                                    n_state = S_FILL;
                                end
                            end
                        end
                    end
                    K_INS_COL: begin
                        if (r_a > w_cols) begin
                            n_st = ST_RANGE;
                        end else if (w_cols >= w_maxc) begin
                            n_st = ST_CAP;
                        end else begin
                            n_cols = r_cols + CCW'(1);
                            n_fend = w_rows - IW'(1);
                            if (w_rows != '0) begin
                                if (r_a != w_cols) begin
                                    n_i     = '0;
                                    n_iend  = w_rows - IW'(1);
                                    n_j     = w_cols;
                                    n_jbeg  = w_cols;
                                    n_jend  = r_a + IW'(1);
                                    n_jdn   = 1'b1;
                                    n_fill  = 1'b1;
                                    n_state = S_MV_RD;
                                end else begin
                                    n_j     = '0;
                                    n_jend  = w_rows - IW'(1);
                                    n_state = S_FILL;
                                end
                            end
                        end
                    end
                    K_SET_SIZE: begin
                        if ((r_a > w_maxr) || (r_b > w_maxc)) begin
                            n_st = ST_CAP;
                        end else begin
                            n_rows = r_a[RCW-1:0];
                            n_cols = r_b[CCW-1:0];
                        end
                    end
                    default: begin
                        n_st = ST_OK;
                    end
                endcase
            end
            S_RD_WAIT: begin
                n_rd    = w_rd64[31:0];
                n_state = S_DONE;
            end
            S_SW_RA: begin
                n_state = S_SW_RB;
            end
            S_SW_RB: begin
                n_tmp   = i_rdata;
                n_state = S_SW_WA;
            end
            S_SW_WA: begin
                n_state = S_SW_WB;
            end
            S_SW_WB: begin
                if (w_shit) begin
                    n_state = S_DONE;
                end else begin
                    n_j     = w_snext;
                    n_state = S_SW_RA;
                end
            end
            S_MV_RD: begin
                n_state = S_MV_WR;
            end
            S_MV_WR: begin
                if (w_shit) begin
                    n_state = S_MV_NXT;
                end else begin
                    n_j     = w_snext;
                    n_state = S_MV_RD;
                end
            end
            S_MV_NXT: begin
                if (w_shit) begin
                    if (r_fill) begin
                        n_j     = '0;
                        n_jend  = r_fend;
                        n_jdn   = 1'b0;
                        n_state = S_FILL;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_i     = w_snext;
                    n_j     = r_jbeg;
                    n_state = S_MV_RD;
                end
            end
            S_FILL: begin
                if (w_shit) begin
                    n_state = S_DONE;
                end else begin
                    n_j = w_snext;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= '0;
            r_cols  <= '0;
        end else begin
            r_state <= n_state;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
        end
    end

    // Hold walk and payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_a    <= n_a;
        r_b    <= n_b;
        r_i    <= n_i;
        r_j    <= n_j;
        r_iend <= n_iend;
        r_jbeg <= n_jbeg;
        r_jend <= n_jend;
        r_fend <= n_fend;
        r_idn  <= n_idn;
        r_jdn  <= n_jdn;
        r_fill <= n_fill;
        r_val  <= n_val;
        r_tmp  <= n_tmp;
        r_rd   <= n_rd;
        r_st   <= n_st;
    end

    // Report the finished command
    assign o_ready             = (r_state == S_IDLE);
    assign o_done              = (r_state == S_DONE) && i_out_free;
    assign o_result.read_value = r_rd;
    assign o_result.rows_now   = w_rows[6:0];
    assign o_result.cols_now   = w_cols[6:0];
    assign o_result.status     = r_st;

endmodule
`default_nettype wire

// ===== hdl/matrix_row_column_editor_top.sv =====
// Commands: a write, set size or rejected command ends after the decode step, a read
//   waits for the registered read data first; swaps read and write each cell pair in turn;
//   deletes and inserts move each cell by a read and a write and step each walked row,
//   and inserts also zero each new cell. Flow: one command at a time, the next transfer
//   taken at the earliest in the cycle after the result loads, once the cell walk is over.
// Reset: counts go to zero, cell contents stay as they were, no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_row_column_editor_top - row/column table editor
// Takes one command per input transfer, runs it against the cell store and
// hands back one result through an output register.
// ----------------------------------------------------------------------------
module matrix_row_column_editor_top #(
    parameter int MAX_ROWS   = mrce_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = mrce_pkg::MAX_COLS_DEF,
    parameter int DATA_WIDTH = mrce_pkg::DATA_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mrce_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mrce_pkg::t_out_item o_out_data
);

    import mrce_pkg::*;

    localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

    logic                  w_ready, w_done, w_out_free;
    t_out_item             w_result;
    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata, w_rdata;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    assign w_out_free = !r_out_valid || i_out_ready;

    mrce_seq #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && w_ready),
        .i_cmd      (i_in_data),
        .o_ready    (w_ready),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_result   (w_result),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    mrce_ram #(
        .AW (AW),
        .DW (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Track the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the finished result
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= w_result;
        end
    end

    assign o_in_ready  = w_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== hdl/mrce_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrce_checker - port checks of the row/column table editor
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mrce_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire mrce_pkg::t_out_item o_out_data
);

    import mrce_pkg::*;

    // Reset empties the output register and leaves the block ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output valid or not ready after reset");

    // A taken command keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an input transfer");

    // A stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

    // Read data shows only on a successful command
    a_read_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.read_value != '0)) |-> (o_out_data.status == ST_OK))
        else $error("nonzero read value with failing status");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == ST_OK) || (o_out_data.status == ST_RANGE)
                         || (o_out_data.status == ST_CAP)))
        else $error("undefined status code");

endmodule

bind matrix_row_column_editor_top mrce_checker u_mrce_checker (.*);
`default_nettype wire
